/* rtl/htq_pkg.sv */
// shared types, codes and the deadline ordering function of the timer heap
`timescale 1ns / 1ps
package htq_pkg;

  localparam int unsigned MaxTimersDef = 32;
  localparam int unsigned MaxResults   = 32;
  localparam int unsigned IdW          = 6;
  localparam int unsigned TagW         = 16;
  localparam int unsigned DelayW       = 20;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned StW          = 3;
  localparam int unsigned KindW        = 2;
  localparam int unsigned ResCntW      = 6;

  typedef enum logic [KindW-1:0] {
    KIND_SET  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef enum logic [StW-1:0] {
    ST_SET_OK    = 3'd0,
    ST_BAD_DELAY = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EXPIRED   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_CMP,
    S_DEL_WAIT,
    S_REM,
    S_REM_RD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN,
    S_TOP_RD,
    S_TOP_CHK,
    S_TAG_WAIT,
    S_EMIT
  } state_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic    latch_in;
    logic    set_alloc;
    logic    pend_clear;
    status_e pend_st;
    logic    del_start;
    logic    del_load;
    logic    tick_adv;
    logic    rem_start;
    logic    rem_load;
    logic    up_rd;
    logic    up_move;
    logic    place;
    logic    dn_rd;
    logic    dn_move;
    logic    top_rd;
    logic    exp_take;
    logic    exp_tag;
    logic    out_load;
    logic    out_last;
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    kind_e kind;
    logic  delay_zero;
    logic  full;
    logic  id_ok;
    logic  p_is_one;
    logic  rem_is_last;
    logic  up_earlier;
    logic  has_child;
    logic  best_is_hold;
    logic  at_start;
    logic  cnt_zero;
    logic  due;
    logic  out_free;
  } sts_t;

  // a fires before b: signed distance from now, then lower id
  function automatic logic earlier(input logic [TimeW-1:0] da, input logic [IdW-1:0] ia,
                                   input logic [TimeW-1:0] db, input logic [IdW-1:0] ib,
                                   input logic [TimeW-1:0] now);
    logic [TimeW-1:0] ka;
    logic [TimeW-1:0] kb;
    ka = (da - now) ^ {1'b1, {(TimeW-1){1'b0}}};
    kb = (db - now) ^ {1'b1, {(TimeW-1){1'b0}}};
    return (ka < kb) || ((ka == kb) && (ia < ib));
  endfunction

endpackage

/* rtl/htq_datapath.sv */
// heap memories, timer state, compare logic and output register of the timer heap
`timescale 1ns / 1ps
module htq_datapath #(
  parameter int unsigned MAX_TIMERS = htq_pkg::MaxTimersDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  htq_pkg::cmd_t               cmd_i,
  output htq_pkg::sts_t               sts_o,
  input  logic [htq_pkg::KindW-1:0]   in_kind_i,
  input  logic [htq_pkg::DelayW-1:0]  in_delay_i,
  input  logic [htq_pkg::IdW-1:0]     in_id_i,
  input  logic [htq_pkg::TagW-1:0]    in_tag_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [htq_pkg::StW-1:0]     out_st_o,
  output logic [htq_pkg::IdW-1:0]     out_id_o,
  output logic [htq_pkg::TagW-1:0]    out_tag_o,
  output logic                        out_last_o
);

  localparam int unsigned D  = MAX_TIMERS + 1;
  localparam int unsigned IW = $clog2(D);
  localparam int unsigned TW = htq_pkg::TimeW;

  typedef struct packed {
    logic [IW-1:0] id;
    logic [TW-1:0] dl;
  } ent_t;

  // memories: heap by position, tag and position by id
  ent_t                      heap_mem [D];
  logic [IW-1:0]             pos_mem  [D];
  logic [htq_pkg::TagW-1:0]  tag_mem  [D];

  logic [TW-1:0]                now_q;
  logic [IW-1:0]                cnt_q;
  logic [D-1:0]                 act_q;
  htq_pkg::kind_e               kind_q;
  logic [htq_pkg::DelayW-1:0]   delay_q;
  logic [htq_pkg::IdW-1:0]      id_q;
  logic [htq_pkg::TagW-1:0]     tag_q;
  ent_t                         hold_q;
  logic [IW-1:0]                p_q, p_d;
  logic [IW-1:0]                sp_q;
  ent_t                         ra_q, rb_q;
  logic [IW-1:0]                pos_rd_q;
  logic [htq_pkg::TagW-1:0]     tag_rd_q;
  htq_pkg::status_e             pend_st_q;
  logic [IW-1:0]                pend_id_q;
  logic [htq_pkg::TagW-1:0]     pend_tag_q;
  logic                         out_valid_q;
  htq_pkg::status_e             out_st_q;
  logic [IW-1:0]                out_id_q;
  logic [htq_pkg::TagW-1:0]     out_tag_q;
  logic                         out_last_q;

  logic [IW-1:0]  free_id;
  logic [IW:0]    c_w, c1_w, cnt_x;
  logic           has_child, c1_ok, a_earl, b_earl;
  ent_t           best_ab;
  logic [TW-1:0]  rem_t;
  logic           heap_we, pos_we, rda_en, rdb_en;
  logic [IW-1:0]  heap_wa, pos_wa, pos_wd, rda_a, rdb_a;
  ent_t           heap_wd;

  // lowest inactive id
  always_comb begin
    free_id = '0;
    for (int i = MAX_TIMERS; i >= 1; i--) begin
      if (!act_q[i]) free_id = IW'(i);
    end
  end

  // child positions and selection in sift down
  assign c_w       = {p_q, 1'b0};
  assign c1_w      = c_w + 1'b1;
  assign cnt_x     = {1'b0, cnt_q};
  assign has_child = (c_w <= cnt_x);
  assign c1_ok     = (c1_w <= cnt_x);
  assign a_earl    = htq_pkg::earlier(ra_q.dl, htq_pkg::IdW'(ra_q.id),
                                      hold_q.dl, htq_pkg::IdW'(hold_q.id), now_q);
  assign best_ab   = a_earl ? ra_q : hold_q;
  assign b_earl    = c1_ok && htq_pkg::earlier(rb_q.dl, htq_pkg::IdW'(rb_q.id),
                                               best_ab.dl, htq_pkg::IdW'(best_ab.id), now_q);
  assign rem_t     = ra_q.dl - now_q;

  // status to the sequencer
  always_comb begin
    sts_o.kind         = kind_q;
    sts_o.delay_zero   = (delay_q == '0);
    sts_o.full         = (cnt_q == IW'(MAX_TIMERS));
    sts_o.id_ok        = (id_q != '0) && (id_q <= htq_pkg::IdW'(MAX_TIMERS))
                         && act_q[id_q[IW-1:0]];
    sts_o.p_is_one     = (p_q == IW'(1));
    sts_o.rem_is_last  = (p_q == cnt_q);
    sts_o.up_earlier   = htq_pkg::earlier(hold_q.dl, htq_pkg::IdW'(hold_q.id),
                                          ra_q.dl, htq_pkg::IdW'(ra_q.id), now_q);
    sts_o.has_child    = has_child;
    sts_o.best_is_hold = !a_earl && !b_earl;
    sts_o.at_start     = (p_q == sp_q);
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.due          = (rem_t == '0) || rem_t[TW-1];
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // memory port control
  always_comb begin
    heap_we = 1'b0;
    heap_wa = p_q;
    heap_wd = hold_q;
    pos_we  = 1'b0;
    pos_wa  = hold_q.id;
    pos_wd  = p_q;
    rda_en  = 1'b0;
    rda_a   = '0;
    rdb_en  = 1'b0;
    rdb_a   = c1_w[IW-1:0];
    if (cmd_i.place) begin
      heap_we = 1'b1;
      pos_we  = 1'b1;
    end else if (cmd_i.up_move) begin
      heap_we = 1'b1;
      heap_wd = ra_q;
      pos_we  = 1'b1;
      pos_wa  = ra_q.id;
    end else if (cmd_i.dn_move) begin
      heap_we = 1'b1;
      heap_wd = b_earl ? rb_q : ra_q;
      pos_we  = 1'b1;
      pos_wa  = b_earl ? rb_q.id : ra_q.id;
    end
    if (cmd_i.up_rd) begin
      rda_en = 1'b1;
      rda_a  = p_q >> 1;
    end else if (cmd_i.dn_rd) begin
      rda_en = 1'b1;
      rda_a  = c_w[IW-1:0];
      rdb_en = c1_ok;
    end else if (cmd_i.top_rd) begin
      rda_en = 1'b1;
      rda_a  = IW'(1);
    end else if (cmd_i.rem_start) begin
      rda_en = 1'b1;
      rda_a  = cnt_q;
    end
  end

  // heap memory
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (rda_en) ra_q <= heap_mem[rda_a];
    if (rdb_en) rb_q <= heap_mem[rdb_a];
  end

  // position and tag memories
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (cmd_i.set_alloc) tag_mem[free_id] <= tag_q;
    if (cmd_i.del_start) begin
      pos_rd_q <= pos_mem[id_q[IW-1:0]];
      tag_rd_q <= tag_mem[id_q[IW-1:0]];
    end else if (cmd_i.exp_take) begin
      tag_rd_q <= tag_mem[ra_q.id];
    end
  end

  // heap position walker
  always_comb begin
    p_d = p_q;
    if (cmd_i.set_alloc)     p_d = cnt_q + 1'b1;
    else if (cmd_i.del_load) p_d = pos_rd_q;
    else if (cmd_i.exp_take) p_d = IW'(1);
    else if (cmd_i.up_move)  p_d = p_q >> 1;
    else if (cmd_i.dn_move)  p_d = b_earl ? c1_w[IW-1:0] : c_w[IW-1:0];
  end

  // control-bearing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      cnt_q       <= '0;
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick_adv) now_q <= now_q + 1'b1;
      if (cmd_i.set_alloc) cnt_q <= cnt_q + 1'b1;
      else if (cmd_i.rem_start) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.set_alloc) act_q[free_id] <= 1'b1;
      if (cmd_i.del_load) act_q[id_q[IW-1:0]] <= 1'b0;
      if (cmd_i.exp_take) act_q[ra_q.id] <= 1'b0;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (cmd_i.latch_in) begin
      kind_q  <= htq_pkg::kind_e'(in_kind_i);
      delay_q <= in_delay_i;
      id_q    <= in_id_i;
      tag_q   <= in_tag_i;
    end
    if (cmd_i.set_alloc) begin
      hold_q.id <= free_id;
      hold_q.dl <= now_q + TW'(delay_q);
    end else if (cmd_i.rem_load) begin
      hold_q <= ra_q;
    end
    if (cmd_i.rem_load) sp_q <= p_q;
    if (cmd_i.pend_clear) begin
      pend_st_q  <= cmd_i.pend_st;
      pend_id_q  <= '0;
      pend_tag_q <= '0;
    end else if (cmd_i.set_alloc) begin
      pend_st_q  <= htq_pkg::ST_SET_OK;
      pend_id_q  <= free_id;
      pend_tag_q <= '0;
    end else if (cmd_i.del_load) begin
      pend_st_q  <= htq_pkg::ST_DELETED;
      pend_id_q  <= id_q[IW-1:0];
      pend_tag_q <= tag_rd_q;
    end else if (cmd_i.exp_take) begin
      pend_st_q  <= htq_pkg::ST_EXPIRED;
      pend_id_q  <= ra_q.id;
    end else if (cmd_i.exp_tag) begin
      pend_tag_q <= tag_rd_q;
    end
    if (cmd_i.out_load) begin
      out_st_q   <= pend_st_q;
      out_id_q   <= pend_id_q;
      out_tag_q  <= pend_tag_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_st_o    = out_st_q;
  assign out_id_o    = htq_pkg::IdW'(out_id_q);
  assign out_tag_o   = out_tag_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/htq_ctrl.sv */
// sequencer of the timer heap: decode, sift up, sift down, removal and expiry loop
`timescale 1ns / 1ps
module htq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  htq_pkg::sts_t sts_i,
  output htq_pkg::cmd_t cmd_o
);

  htq_pkg::state_e              state_q, state_d;
  logic [htq_pkg::ResCntW-1:0]  n_q, n_d;
  logic                         pend_q, pend_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htq_pkg::S_IDLE;
      n_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    cmd_o.pend_st = htq_pkg::ST_EXPIRED;
    in_ready_o = 1'b0;
    unique case (state_q)
      htq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = htq_pkg::S_DECODE;
        end
      end
      htq_pkg::S_DECODE: begin
        unique case (sts_i.kind)
          htq_pkg::KIND_SET: begin
            if (sts_i.delay_zero) begin
              cmd_o.pend_clear = 1'b1;
              cmd_o.pend_st    = htq_pkg::ST_BAD_DELAY;
              state_d          = htq_pkg::S_EMIT;
            end else if (sts_i.full) begin
              cmd_o.pend_clear = 1'b1;
              cmd_o.pend_st    = htq_pkg::ST_FULL;
              state_d          = htq_pkg::S_EMIT;
            end else begin
              cmd_o.set_alloc = 1'b1;
              state_d         = htq_pkg::S_UP_RD;
            end
          end
          htq_pkg::KIND_DEL: begin
            if (sts_i.id_ok) begin
              cmd_o.del_start = 1'b1;
              state_d         = htq_pkg::S_DEL_WAIT;
            end else begin
              cmd_o.pend_clear = 1'b1;
              cmd_o.pend_st    = htq_pkg::ST_NOT_FOUND;
              state_d          = htq_pkg::S_EMIT;
            end
          end
          htq_pkg::KIND_TICK: begin
            cmd_o.tick_adv = 1'b1;
            n_d            = '0;
            pend_d         = 1'b0;
            state_d        = htq_pkg::S_TOP_RD;
          end
          default: state_d = htq_pkg::S_IDLE;
        endcase
      end
      // sift up: compare held entry with parent
      htq_pkg::S_UP_RD: begin
        if (sts_i.p_is_one) begin
          cmd_o.place = 1'b1;
          state_d     = htq_pkg::S_FIN;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d     = htq_pkg::S_UP_CMP;
        end
      end
      htq_pkg::S_UP_CMP: begin
        if (sts_i.up_earlier) begin
          cmd_o.up_move = 1'b1;
          state_d       = htq_pkg::S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = htq_pkg::S_FIN;
        end
      end
      htq_pkg::S_DEL_WAIT: begin
        cmd_o.del_load = 1'b1;
        state_d        = htq_pkg::S_REM;
      end
      // removal: last entry refills the hole
      htq_pkg::S_REM: begin
        cmd_o.rem_start = 1'b1;
        state_d = sts_i.rem_is_last ? htq_pkg::S_FIN : htq_pkg::S_REM_RD;
      end
      htq_pkg::S_REM_RD: begin
        cmd_o.rem_load = 1'b1;
        state_d        = htq_pkg::S_DN_RD;
      end
      // sift down: fetch both children, the second only where it exists
      htq_pkg::S_DN_RD: begin
        if (sts_i.has_child) begin
          cmd_o.dn_rd = 1'b1;
          state_d     = htq_pkg::S_DN_CMP;
        end else if (sts_i.at_start) begin
          state_d = htq_pkg::S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = htq_pkg::S_FIN;
        end
      end
      htq_pkg::S_DN_CMP: begin
        if (!sts_i.best_is_hold) begin
          cmd_o.dn_move = 1'b1;
          state_d       = htq_pkg::S_DN_RD;
        end else if (sts_i.at_start) begin
          state_d = htq_pkg::S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = htq_pkg::S_FIN;
        end
      end
      htq_pkg::S_FIN: begin
        state_d = (sts_i.kind == htq_pkg::KIND_TICK) ? htq_pkg::S_TOP_RD : htq_pkg::S_EMIT;
      end
      // expiry loop: look at the heap top
      htq_pkg::S_TOP_RD: begin
        if (sts_i.cnt_zero || (n_q == htq_pkg::ResCntW'(htq_pkg::MaxResults))) begin
          if (!pend_q) cmd_o.pend_clear = 1'b1;
          state_d = htq_pkg::S_EMIT;
        end else begin
          cmd_o.top_rd = 1'b1;
          state_d      = htq_pkg::S_TOP_CHK;
        end
      end
      htq_pkg::S_TOP_CHK: begin
        if (!sts_i.due) begin
          if (!pend_q) cmd_o.pend_clear = 1'b1;
          state_d = htq_pkg::S_EMIT;
        end else if (pend_q) begin
          // another timer due: the held report is not the last
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            pend_d         = 1'b0;
          end
        end else begin
          cmd_o.exp_take = 1'b1;
          n_d            = n_q + 1'b1;
          state_d        = htq_pkg::S_TAG_WAIT;
        end
      end
      htq_pkg::S_TAG_WAIT: begin
        cmd_o.exp_tag = 1'b1;
        pend_d        = 1'b1;
        state_d       = htq_pkg::S_REM;
      end
      htq_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          pend_d         = 1'b0;
          state_d        = htq_pkg::S_IDLE;
        end
      end
      default: state_d = htq_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/heap_timer_queue_core.sv */
// top level of the one-shot timer queue kept as a binary min-heap
`timescale 1ns / 1ps
// Usage:
// - slave channel takes one request beat: tuser is the kind (set, delete,
//   tick), tdata carries delay, timer id and tag. One request at a time.
// - master channel returns result beats; the last beat of a request has
//   tlast set. A tick gives one beat per due timer, earliest first, or one
//   "none due" beat.
// - set: takes the lowest free id, then sifts up one heap level per compare.
// - delete: the last entry refills the hole, then sifts down or sifts up.
// - tick: advances time; each due timer leaves the top, the last entry
//   refills the hole and sifts down. Sift down reads the children of a level
//   at once from the heap memory, with registered data, then compares.
// - reset clears time, the timer count and the active flags at once; no
//   clearing pass, the first request can be sent right after reset.
// - a stalled master side holds the result beat; the sequencer waits until
//   the output register is free before it moves on.
module heap_timer_queue_core #(
  parameter int unsigned MAX_TIMERS = htq_pkg::MaxTimersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // delay_ticks[19:0], target_id[25:20], tag[41:26], zero
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // result_id[5:0], result_tag[21:6], zero
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast
);

  htq_pkg::cmd_t              cmd;
  htq_pkg::sts_t              sts;
  logic [htq_pkg::IdW-1:0]    res_id;
  logic [htq_pkg::TagW-1:0]   res_tag;

  // sequencer
  htq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // heap storage and compare logic
  htq_datapath #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (s_axis_tuser),
    .in_delay_i  (s_axis_tdata[19:0]),
    .in_id_i     (s_axis_tdata[25:20]),
    .in_tag_i    (s_axis_tdata[41:26]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_st_o    (m_axis_tuser),
    .out_id_o    (res_id),
    .out_tag_o   (res_tag),
    .out_last_o  (m_axis_tlast)
  );

  // result beat packing
  assign m_axis_tdata = {2'b00, res_tag, res_id};

endmodule

/* rtl/htq_checker.sv */
// port-level checks of the timer queue and their binding to the top level
`timescale 1ns / 1ps
module htq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a result beat held under backpressure stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed under backpressure");

  // one request at a time: an accepted beat closes the input
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

  // set, reject and delete results are single beats
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != htq_pkg::ST_EXPIRED) |-> m_axis_tlast)
    else $error("non-expiry result without tlast");

  // rejects carry no id and no tag
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == htq_pkg::ST_BAD_DELAY)
    || (m_axis_tuser == htq_pkg::ST_FULL) || (m_axis_tuser == htq_pkg::ST_NOT_FOUND))
    |-> m_axis_tdata == '0)
    else $error("reject result carries data");

endmodule

bind heap_timer_queue_core htq_checker u_htq_checker (.*);

/* dv/heap_timer_queue_core_tb.sv */
// testbench for the timer heap queue: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module heap_timer_queue_core_tb;

  localparam int unsigned NTIM = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    htq_pkg::status_e                st;
    logic [htq_pkg::IdW-1:0]         id;
    logic [htq_pkg::TagW-1:0]        tg;
    logic                            last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // delay_ticks[19:0], target_id[25:20], tag[41:26], zero
  logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // result_id[5:0], result_tag[21:6], zero
  logic [2:0]  m_axis_tuser;        // status[2:0]
  logic        m_axis_tlast;

  heap_timer_queue_core #(.MAX_TIMERS(NTIM)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // predictor state: flat list of active timers, min search gives heap order
  logic [htq_pkg::TimeW-1:0] now_q;
  logic [htq_pkg::TimeW-1:0] dl_q [1:NTIM];
  logic [htq_pkg::TagW-1:0]  tag_q [1:NTIM];
  logic                      act_q [1:NTIM];
  int unsigned               n_active;

  beat_t result_fifo [$];
  int    errors = 0;
  int    cycles = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_off = 0;

  initial forever #5 clk_i = ~clk_i;

  // work out the result beats of one request
  task automatic predict_request(input htq_pkg::kind_e k,
                                 input logic [htq_pkg::DelayW-1:0] d,
                                 input logic [htq_pkg::IdW-1:0] id,
                                 input logic [htq_pkg::TagW-1:0] tg);
    int    e;
    int    n;
    int    best;
    beat_t b;
    logic [htq_pkg::TimeW-1:0] rem;
    case (k)
      htq_pkg::KIND_SET: begin
        if (d == 0) begin
          result_fifo.push_back(beat_t'{htq_pkg::ST_BAD_DELAY, 6'd0, 16'd0, 1'b1});
        end else if (n_active >= NTIM) begin
          result_fifo.push_back(beat_t'{htq_pkg::ST_FULL, 6'd0, 16'd0, 1'b1});
        end else begin
          e = 1;
          while (act_q[e]) e++;
          act_q[e] = 1'b1;
          dl_q[e] = now_q + d;
          tag_q[e] = tg;
          n_active++;
          result_fifo.push_back(beat_t'{htq_pkg::ST_SET_OK, e[htq_pkg::IdW-1:0], 16'd0,
                                        1'b1});
        end
      end
      htq_pkg::KIND_DEL: begin
        if (id == 0 || id > NTIM || !act_q[id]) begin
          result_fifo.push_back(beat_t'{htq_pkg::ST_NOT_FOUND, 6'd0, 16'd0, 1'b1});
        end else begin
          act_q[id] = 1'b0;
          n_active--;
          result_fifo.push_back(beat_t'{htq_pkg::ST_DELETED, id, tag_q[id], 1'b1});
        end
      end
      htq_pkg::KIND_TICK: begin
        now_q++;
        n = 0;
        while (n_active > 0 && n < htq_pkg::MaxResults) begin
          best = 0;
          for (int i = 1; i <= NTIM; i++)
            if (act_q[i] && (best == 0 ||
                ((dl_q[i] - now_q) ^ 32'h8000_0000) < ((dl_q[best] - now_q) ^ 32'h8000_0000)))
              best = i;
          rem = dl_q[best] - now_q;
          if (rem != 0 && !rem[31]) break;
          result_fifo.push_back(beat_t'{htq_pkg::ST_EXPIRED, best[htq_pkg::IdW-1:0],
                                        tag_q[best], 1'b0});
          act_q[best] = 1'b0;
          n_active--;
          n++;
        end
        if (n == 0) begin
          result_fifo.push_back(beat_t'{htq_pkg::ST_EXPIRED, 6'd0, 16'd0, 1'b1});
        end else begin
          b = result_fifo.pop_back();
          b.last = 1'b1;
          result_fifo.push_back(b);
        end
      end
      default: ;
    endcase
  endtask

  // offer one request beat and wait until it is taken
  task automatic send_request(input htq_pkg::kind_e k,
                              input logic [htq_pkg::DelayW-1:0] d,
                              input logic [htq_pkg::IdW-1:0] id,
                              input logic [htq_pkg::TagW-1:0] tg);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {6'd0, tg, id, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(k, d, id, tg);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver ready with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    beat_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_fifo.size() == 0) begin
        $display("%0t unexpected beat: st %0d id %0d tag %0h last %0b", $time,
                 m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tlast);
        errors++;
      end else begin
        exp_b = result_fifo.pop_front();
        if (m_axis_tuser != exp_b.st || m_axis_tdata[5:0] != exp_b.id ||
            m_axis_tdata[21:6] != exp_b.tg || m_axis_tdata[23:22] != 2'b00 ||
            m_axis_tlast != exp_b.last) begin
          $display("%0t mismatch: expected st %0d id %0d tag %0h last %0b,",
                   $time, exp_b.st, exp_b.id, exp_b.tg, exp_b.last,
                   " got st %0d id %0d tag %0h last %0b", m_axis_tuser,
                   m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // field extremes, bad delay, not found, reserved kind, idle tick
  task automatic test_directed();
    send_request(htq_pkg::KIND_SET, 20'd0, 6'd0, 16'hFFFF);
    send_request(htq_pkg::KIND_TICK, 20'd0, 6'd0, 16'd0);
    send_request(htq_pkg::KIND_SET, 20'hFFFFF, 6'h3F, 16'hFFFF);
    send_request(htq_pkg::KIND_SET, 20'd1, 6'd0, 16'h0000);
    send_request(htq_pkg::KIND_SET, 20'd1, 6'd0, 16'hA5A5);
    send_request(htq_pkg::KIND_SET, 20'd2, 6'd0, 16'h5A5A);
    send_request(htq_pkg::KIND_RSVD, 20'hFFFFF, 6'h3F, 16'hFFFF);
    send_request(htq_pkg::KIND_DEL, 20'hFFFFF, 6'd0, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'h3F, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd33, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd20, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd3, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd1, 16'd0);
    send_request(htq_pkg::KIND_TICK, 20'd0, 6'd0, 16'd0);
    send_request(htq_pkg::KIND_TICK, 20'd0, 6'd0, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd2, 16'hFFFF);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd2, 16'd0);
    wait_drained();
  endtask

  // fill the queue with the same deadline while the receiver holds off,
  // then overfill and expire a full tick worth of timers
  task automatic test_full_and_burst();
    hold_off <= 300;
    for (int i = 0; i < 34; i++)
      send_request(htq_pkg::KIND_SET, 20'd2, 6'd0, 16'(i * 977));
    send_request(htq_pkg::KIND_TICK, 20'd0, 6'd0, 16'd0);
    send_request(htq_pkg::KIND_TICK, 20'd0, 6'd0, 16'd0);
    wait_drained();
    // sender pauses here until all is drained, then probes the empty queue
    send_request(htq_pkg::KIND_TICK, 20'd0, 6'd0, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd1, 16'd0);
    send_request(htq_pkg::KIND_DEL, 20'd0, 6'd32, 16'd0);
    wait_drained();
  endtask

  // random mix: short delays so timers expire, some long and some junk
  task automatic test_random(input int count);
    int r;
    logic [htq_pkg::DelayW-1:0] d;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        d = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(6));
        send_request(htq_pkg::KIND_SET, d, 6'($urandom), 16'($urandom));
      end else if (r < 55) begin
        send_request(htq_pkg::KIND_DEL, 20'($urandom),
                     ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 8)),
                     16'($urandom));
      end else if (r < 97) begin
        send_request(htq_pkg::KIND_TICK, 20'($urandom), 6'($urandom), 16'($urandom));
      end else begin
        send_request(htq_pkg::KIND_RSVD, 20'($urandom), 6'($urandom), 16'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    now_q = '0;
    n_active = 0;
    for (int i = 1; i <= NTIM; i++) begin
      act_q[i] = 1'b0;
      dl_q[i] = '0;
      tag_q[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 32;
    recv_idle_pct = 56;
    test_directed();
    test_full_and_burst();
    test_random(15);
    send_idle_pct = 56;
    recv_idle_pct = 32;
    test_random(15);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(15);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/htq_pkg.sv
rtl/htq_datapath.sv
rtl/htq_ctrl.sv
rtl/heap_timer_queue_core.sv
rtl/htq_checker.sv
dv/heap_timer_queue_core_tb.sv
